@@ hdl/mlos_pkg.sv @@
// Shared constants, types and the control store of the lattice oscillator step.
package mlos_pkg;

   // Field and register widths
   localparam int POSITION_WIDTH  = 16;
   localparam int DRAW_BITS       = 16;
   localparam int BETA_WIDTH      = 16;
   localparam int STEP_WIDTH      = 2;

   // beta*dE is held in units of 2^-9 (8 beta fraction bits plus the half)
   localparam int FRAC_BITS       = 9;
   localparam int X_WIDTH         = BETA_WIDTH + POSITION_WIDTH;
   localparam int WHOLE_BITS      = 5;
   localparam int F_WIDTH         = FRAC_BITS + 1;

   // Q32 exponential values; one extra bit holds exactly 1.0
   localparam int Q_BITS          = 32;
   localparam int VAL_WIDTH       = Q_BITS + 1;
   localparam int SUM_WIDTH       = VAL_WIDTH + 1;
   localparam int TPROD_WIDTH     = VAL_WIDTH + F_WIDTH;

   // Taylor series and its per-term divider
   localparam int SERIES_TERMS    = 20;
   localparam int K_WIDTH         = $clog2(SERIES_TERMS + 1);
   localparam int DIV_STEP        = 8;
   localparam int DIV_CHUNKS      = (VAL_WIDTH + DIV_STEP - 1) / DIV_STEP;
   localparam int DIV_WIDTH       = DIV_CHUNKS * DIV_STEP;
   localparam int CHUNK_WIDTH     = $clog2(DIV_CHUNKS);

   // exp(-1) product split into two narrow multiplies
   localparam int E1_LO_BITS      = 16;
   localparam int E1_HI_BITS      = VAL_WIDTH - E1_LO_BITS;
   localparam int PLO_WIDTH       = VAL_WIDTH + E1_LO_BITS;
   localparam int PHI_WIDTH       = VAL_WIDTH + E1_HI_BITS + 1;

   localparam logic [VAL_WIDTH-1:0] Q_ONE = VAL_WIDTH'(1) << Q_BITS;
   localparam logic [F_WIDTH-1:0]   F_ONE = F_WIDTH'(1) << FRAC_BITS;

   localparam logic signed [STEP_WIDTH-1:0] STEP_PLUS  = 2'sb01;
   localparam logic signed [STEP_WIDTH-1:0] STEP_MINUS = 2'sb11;

   // Register map
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int ADDR_LSB        = 2;
   localparam int REG_INDEX_WIDTH = 1;
   localparam int CSR_ADDR_WIDTH  = ADDR_LSB + REG_INDEX_WIDTH;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_BETA  = 1'b0;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_START = 1'b1;
   localparam logic [BETA_WIDTH-1:0]      BETA_RESET = 16'd256;

   // Sequencer
   localparam int PC_WIDTH = 4;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_CLASS,
      OP_NOP,
      OP_SPLIT,
      OP_TMUL,
      OP_TDIV,
      OP_TACC,
      OP_SERDONE,
      OP_EMUL_LO,
      OP_EMUL_HI,
      OP_TAKE_CMP,
      OP_TAKE_YES,
      OP_TAKE_NO,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      C_ALWAYS,
      C_NO_ITEM,
      C_OOR,
      C_DOWNHILL,
      C_BIG,
      C_DIV_MORE,
      C_TERMS_MORE,
      C_SER_AGAIN,
      C_WHOLE_ZERO,
      C_WHOLE_MORE
   } cond_type;

   typedef struct packed {
      op_type               op;
      cond_type             cond;
      logic [PC_WIDTH-1:0]  target;
   } ctl_type;

   typedef struct packed {
      logic no_item;
      logic oor;
      logic downhill;
      logic big;
      logic div_more;
      logic terms_more;
      logic ser_again;
      logic whole_zero;
      logic whole_more;
      logic emit_hold;
   } status_type;

   // Program addresses
   localparam logic [PC_WIDTH-1:0] A_IDLE    = PC_WIDTH'(0);
   localparam logic [PC_WIDTH-1:0] A_CLASS   = PC_WIDTH'(1);
   localparam logic [PC_WIDTH-1:0] A_SLOPE   = PC_WIDTH'(2);
   localparam logic [PC_WIDTH-1:0] A_SPLIT   = PC_WIDTH'(3);
   localparam logic [PC_WIDTH-1:0] A_TMUL    = PC_WIDTH'(4);
   localparam logic [PC_WIDTH-1:0] A_TDIV    = PC_WIDTH'(5);
   localparam logic [PC_WIDTH-1:0] A_TACC    = PC_WIDTH'(6);
   localparam logic [PC_WIDTH-1:0] A_SERDONE = PC_WIDTH'(7);
   localparam logic [PC_WIDTH-1:0] A_WCHECK  = PC_WIDTH'(8);
   localparam logic [PC_WIDTH-1:0] A_EMUL_LO = PC_WIDTH'(9);
   localparam logic [PC_WIDTH-1:0] A_EMUL_HI = PC_WIDTH'(10);
   localparam logic [PC_WIDTH-1:0] A_CMP     = PC_WIDTH'(11);
   localparam logic [PC_WIDTH-1:0] A_YES     = PC_WIDTH'(12);
   localparam logic [PC_WIDTH-1:0] A_NO      = PC_WIDTH'(13);
   localparam logic [PC_WIDTH-1:0] A_EMIT    = PC_WIDTH'(14);

   // Control store: a word jumps to target when its condition holds,
   // otherwise the step counter advances.
   function automatic ctl_type ucode(input logic [PC_WIDTH-1:0] pc);
      ctl_type w;
      unique case (pc)
         A_IDLE:    w = '{op: OP_IDLE,     cond: C_NO_ITEM,    target: A_IDLE};
         A_CLASS:   w = '{op: OP_CLASS,    cond: C_OOR,        target: A_NO};
         A_SLOPE:   w = '{op: OP_NOP,      cond: C_DOWNHILL,   target: A_YES};
         A_SPLIT:   w = '{op: OP_SPLIT,    cond: C_BIG,        target: A_NO};
         A_TMUL:    w = '{op: OP_TMUL,     cond: C_ALWAYS,     target: A_TDIV};
         A_TDIV:    w = '{op: OP_TDIV,     cond: C_DIV_MORE,   target: A_TDIV};
         A_TACC:    w = '{op: OP_TACC,     cond: C_TERMS_MORE, target: A_TMUL};
         A_SERDONE: w = '{op: OP_SERDONE,  cond: C_SER_AGAIN,  target: A_TMUL};
         A_WCHECK:  w = '{op: OP_NOP,      cond: C_WHOLE_ZERO, target: A_CMP};
         A_EMUL_LO: w = '{op: OP_EMUL_LO,  cond: C_ALWAYS,     target: A_EMUL_HI};
         A_EMUL_HI: w = '{op: OP_EMUL_HI,  cond: C_WHOLE_MORE, target: A_EMUL_LO};
         A_CMP:     w = '{op: OP_TAKE_CMP, cond: C_ALWAYS,     target: A_EMIT};
         A_YES:     w = '{op: OP_TAKE_YES, cond: C_ALWAYS,     target: A_EMIT};
         A_NO:      w = '{op: OP_TAKE_NO,  cond: C_ALWAYS,     target: A_EMIT};
         A_EMIT:    w = '{op: OP_EMIT,     cond: C_ALWAYS,     target: A_IDLE};
         default:   w = '{op: OP_NOP,      cond: C_ALWAYS,     target: A_IDLE};
      endcase
      return w;
   endfunction

endpackage

@@ hdl/metropolis_lattice_oscillator_step.sv @@
// Top level of the Metropolis lattice oscillator step: register port, sequencer, datapath.
//
// Usage:
//   Each req_ item carries two uniform draws; the block proposes a +1 or -1 step
//   of the walker, decides it with the Metropolis rule at inverse temperature
//   beta, and returns one rsp_ item (new position, proposed step, accepted).
//   Both channels move an item at a clock edge with valid high and stall low.
//   Registers: beta at byte address 0 (u8.8, reset 256), start_position at 4
//   (reset 0); a start_position write also loads the walker. Write only while idle.
// Work per item by path:
//   move leaving the position range, downhill move, or beta*dE of 32 or more:
//   no series; fraction only: one exp series; whole part I of 1..31: a second
//   series at x = 1 for exp(-1), then I exp(-1) factors. Each series has 20
//   terms: per term one multiply and a division in chunks of 8 quotient bits,
//   plus two narrow multiplies per exp(-1) factor.
//   One item is in flight at a time; the next item is taken as soon as the
//   sequencer is back at its idle word, even while the last result waits.
// Reset: synchronous, active high; sequencer returns to idle, walker to 0,
//   beta to 256. A stalled result holds in the output register and the
//   sequencer waits on its result step until the slot frees.
module metropolis_lattice_oscillator_step
   import mlos_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [DRAW_BITS-1:0]              req_direction_draw,
   input  logic [DRAW_BITS-1:0]              req_accept_draw,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [POSITION_WIDTH-1:0]  rsp_new_position,
   output logic signed [STEP_WIDTH-1:0]      rsp_step_taken,
   output logic                              rsp_accepted,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]         csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0]         csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]         csr_prdata,
   output logic                              csr_pready
);

   logic [BETA_WIDTH-1:0]            beta_ff, beta_in;
   logic signed [POSITION_WIDTH-1:0] start_ff, start_in;
   logic [REG_INDEX_WIDTH-1:0]       reg_index;
   logic                             csr_wr;
   logic                             load_start;
   logic signed [POSITION_WIDTH-1:0] start_value;
   ctl_type                          ctl;
   status_type                       status;
   logic signed [POSITION_WIDTH-1:0] walker_position;
   logic                             emit_fire;
   logic signed [POSITION_WIDTH-1:0] step_ext;

   // ------------------------------------------------------------------
   // Register port: zero wait states, write on the access phase
   // ------------------------------------------------------------------
   assign csr_pready  = 1'b1;
   assign reg_index   = csr_paddr[ADDR_LSB +: REG_INDEX_WIDTH];
   assign csr_wr      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign start_value = csr_pwdata[POSITION_WIDTH-1:0];
   assign load_start  = csr_wr & (reg_index == REG_START);

   always_comb begin
      beta_in  = beta_ff;
      start_in = start_ff;
      if (csr_wr) begin
         unique case (reg_index)
            REG_BETA:  beta_in  = csr_pwdata[BETA_WIDTH-1:0];
            REG_START: start_in = start_value;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff  <= BETA_RESET;
         start_ff <= '0;
      end else begin
         beta_ff  <= beta_in;
         start_ff <= start_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_BETA:  csr_prdata = CSR_DATA_WIDTH'(beta_ff);
         REG_START: csr_prdata = CSR_DATA_WIDTH'(start_ff);
         default:   csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Control: the sequencer walks the program; items enter only at idle
   // ------------------------------------------------------------------
   mlos_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   assign req_stall = ctl.op != OP_IDLE;

   // ------------------------------------------------------------------
   // Datapath: walker, exp series, decision and output register
   // ------------------------------------------------------------------
   mlos_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .beta               (beta_ff),
      .load_start         (load_start),
      .start_value        (start_value),
      .req_valid          (req_valid),
      .req_direction_draw (req_direction_draw),
      .req_accept_draw    (req_accept_draw),
      .rsp_stall          (rsp_stall),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_new_position   (rsp_new_position),
      .rsp_step_taken     (rsp_step_taken),
      .rsp_accepted       (rsp_accepted),
      .walker_position    (walker_position)
   );

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   assign emit_fire = (ctl.op == OP_EMIT) & ~status.emit_hold;
   assign step_ext  = POSITION_WIDTH'(rsp_step_taken);

   // a new result moves the walker by exactly the step when taken, else not at all
   assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> rsp_valid &&
         (rsp_accepted ? (rsp_new_position == $past(walker_position) + step_ext)
                       : (rsp_new_position == $past(walker_position))))
      else $error("result position does not follow the walker");

   // an accepted move never wraps around the position range
   assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> !(rsp_accepted &&
         ((rsp_step_taken == STEP_PLUS && rsp_new_position ==
              {1'b1, {(POSITION_WIDTH-1){1'b0}}}) ||
          (rsp_step_taken == STEP_MINUS && rsp_new_position ==
              {1'b0, {(POSITION_WIDTH-1){1'b1}}}))))
      else $error("accepted move wrapped the walker position");

   // a start_position write loads the walker
   assert property (@(posedge clock) disable iff (reset)
      load_start |=> walker_position == $past(start_value))
      else $error("start_position write did not load the walker");

endmodule

@@ hdl/mlos_sequencer.sv @@
// Step counter and branch logic that walks the control store.
module mlos_sequencer
   import mlos_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctl_type    ctl
);

   logic [PC_WIDTH-1:0] pc_ff;
   logic [PC_WIDTH-1:0] pc_in;
   logic                jump;
   logic                hold;

   assign ctl = ucode(pc_ff);

   always_comb begin
      unique case (ctl.cond)
         C_ALWAYS:     jump = 1'b1;
         C_NO_ITEM:    jump = status.no_item;
         C_OOR:        jump = status.oor;
         C_DOWNHILL:   jump = status.downhill;
         C_BIG:        jump = status.big;
         C_DIV_MORE:   jump = status.div_more;
         C_TERMS_MORE: jump = status.terms_more;
         C_SER_AGAIN:  jump = status.ser_again;
         C_WHOLE_ZERO: jump = status.whole_zero;
         C_WHOLE_MORE: jump = status.whole_more;
         default:      jump = 1'b1;
      endcase
   end

   // hold the result step while the output slot is still occupied
   assign hold = (ctl.op == OP_EMIT) && status.emit_hold;

   always_comb begin
      priority if (hold) begin
         pc_in = pc_ff;
      end else if (jump) begin
         pc_in = ctl.target;
      end else begin
         pc_in = pc_ff + PC_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= A_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

@@ hdl/mlos_datapath.sv @@
// Datapath: walker state, series unit with chunked divider, exp(-1) products, result register.
module mlos_datapath
   import mlos_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  ctl_type                           ctl,
   input  logic [BETA_WIDTH-1:0]             beta,
   input  logic                              load_start,
   input  logic signed [POSITION_WIDTH-1:0]  start_value,
   input  logic                              req_valid,
   input  logic [DRAW_BITS-1:0]              req_direction_draw,
   input  logic [DRAW_BITS-1:0]              req_accept_draw,
   input  logic                              rsp_stall,
   output status_type                        status,
   output logic                              rsp_valid,
   output logic signed [POSITION_WIDTH-1:0]  rsp_new_position,
   output logic signed [STEP_WIDTH-1:0]      rsp_step_taken,
   output logic                              rsp_accepted,
   output logic signed [POSITION_WIDTH-1:0]  walker_position
);

   localparam logic signed [POSITION_WIDTH-1:0] POS_MAX = {1'b0, {(POSITION_WIDTH-1){1'b1}}};
   localparam logic signed [POSITION_WIDTH-1:0] POS_MIN = {1'b1, {(POSITION_WIDTH-1){1'b0}}};

   logic signed [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic                             neg_ff, neg_in;
   logic [DRAW_BITS-1:0]             draw_ff, draw_in;
   logic [X_WIDTH-1:0]               x_ff, x_in;
   logic [F_WIDTH-1:0]               f_ff, f_in;
   logic [WHOLE_BITS-1:0]            whole_ff, whole_in;
   logic [VAL_WIDTH-1:0]             term_ff, term_in;
   logic [SUM_WIDTH-1:0]             sum_ff, sum_in;
   logic [K_WIDTH-1:0]               k_ff, k_in;
   logic [CHUNK_WIDTH-1:0]           chunk_ff, chunk_in;
   logic [DIV_WIDTH-1:0]             divq_ff, divq_in;
   logic [K_WIDTH-1:0]               rem_ff, rem_in;
   logic [VAL_WIDTH-1:0]             e_ff, e_in;
   logic [VAL_WIDTH-1:0]             e1_ff, e1_in;
   logic [PLO_WIDTH-1:0]             plo_ff, plo_in;
   logic                             phase_ff, phase_in;
   logic                             take_ff, take_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [POSITION_WIDTH-1:0] rsp_pos_ff, rsp_pos_in;
   logic signed [STEP_WIDTH-1:0]     rsp_step_ff, rsp_step_in;
   logic                             rsp_acc_ff, rsp_acc_in;

   logic                             dir_neg;
   logic [POSITION_WIDTH-1:0]        mag;
   logic [POSITION_WIDTH-1:0]        odd;
   logic [X_WIDTH-1:0]               x_prod;
   logic [TPROD_WIDTH-1:0]           tprod;
   logic [DIV_WIDTH-1:0]             div_d;
   logic [K_WIDTH-1:0]               div_r;
   logic [K_WIDTH:0]                 trial;
   logic [PHI_WIDTH-1:0]             phi;
   logic [DRAW_BITS:0]               limit;
   logic signed [POSITION_WIDTH-1:0] step_ext;
   logic signed [POSITION_WIDTH-1:0] cand;
   logic                             emit_hold;

   // step is -1 only for draws strictly above half scale
   assign dir_neg  = req_direction_draw[DRAW_BITS-1] & (|req_direction_draw[DRAW_BITS-2:0]);
   assign step_ext = neg_ff ? '1 : POSITION_WIDTH'(1);
   assign cand     = pos_ff + step_ext;

   // X = beta * (2*|a*n| + 1), exact in units of 2^-9
   assign mag    = neg_ff ? POSITION_WIDTH'(-pos_ff) : POSITION_WIDTH'(pos_ff);
   assign odd    = {mag[POSITION_WIDTH-2:0], 1'b1};
   assign x_prod = X_WIDTH'(beta) * X_WIDTH'(odd);

   assign tprod  = TPROD_WIDTH'(term_ff) * TPROD_WIDTH'(f_ff);

   // restoring division by k, DIV_STEP quotient bits per cycle
   always_comb begin
      div_r = rem_ff;
      div_d = divq_ff;
      trial = '0;
      for (int i = 0; i < DIV_STEP; i++) begin
         trial = {div_r, div_d[DIV_WIDTH-1]};
         div_d = {div_d[DIV_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, k_ff}) begin
            trial    = trial - {1'b0, k_ff};
            div_d[0] = 1'b1;
         end
         div_r = trial[K_WIDTH-1:0];
      end
   end

   // (e * E1) >> 32 = (e * E1_hi + (e * E1_lo >> 16)) >> 16
   assign phi = PHI_WIDTH'(e_ff) * PHI_WIDTH'(e1_ff[VAL_WIDTH-1:E1_LO_BITS])
              + PHI_WIDTH'(plo_ff >> E1_LO_BITS);

   assign limit = e_ff[Q_BITS -: (DRAW_BITS + 1)];

   assign emit_hold = rsp_valid_ff & rsp_stall;

   assign status.no_item    = ~req_valid;
   assign status.oor        = neg_ff ? (pos_ff == POS_MIN) : (pos_ff == POS_MAX);
   assign status.downhill   = neg_ff ? ((pos_ff != '0) & ~pos_ff[POSITION_WIDTH-1])
                                     : pos_ff[POSITION_WIDTH-1];
   assign status.big        = |x_ff[X_WIDTH-1:FRAC_BITS+WHOLE_BITS];
   assign status.div_more   = chunk_ff != CHUNK_WIDTH'(DIV_CHUNKS - 1);
   assign status.terms_more = k_ff != K_WIDTH'(SERIES_TERMS);
   assign status.ser_again  = ~phase_ff & (whole_ff != '0);
   assign status.whole_zero = whole_ff == '0;
   assign status.whole_more = whole_ff != WHOLE_BITS'(1);
   assign status.emit_hold  = emit_hold;

   always_comb begin
      pos_in       = pos_ff;
      neg_in       = neg_ff;
      draw_in      = draw_ff;
      x_in         = x_ff;
      f_in         = f_ff;
      whole_in     = whole_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      k_in         = k_ff;
      chunk_in     = chunk_ff;
      divq_in      = divq_ff;
      rem_in       = rem_ff;
      e_in         = e_ff;
      e1_in        = e1_ff;
      plo_in       = plo_ff;
      phase_in     = phase_ff;
      take_in      = take_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_step_in  = rsp_step_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      if (load_start) begin
         pos_in = start_value;
      end

      unique case (ctl.op)
         OP_IDLE: begin
            if (req_valid) begin
               neg_in  = dir_neg;
               draw_in = req_accept_draw;
            end
         end
         OP_CLASS: begin
            x_in = x_prod;
         end
         OP_SPLIT: begin
            f_in     = F_WIDTH'(x_ff[FRAC_BITS-1:0]);
            whole_in = x_ff[FRAC_BITS +: WHOLE_BITS];
            term_in  = Q_ONE;
            sum_in   = SUM_WIDTH'(Q_ONE);
            k_in     = K_WIDTH'(1);
            phase_in = 1'b0;
         end
         OP_TMUL: begin
            divq_in  = DIV_WIDTH'(tprod[FRAC_BITS +: VAL_WIDTH]);
            rem_in   = '0;
            chunk_in = '0;
         end
         OP_TDIV: begin
            divq_in  = div_d;
            rem_in   = div_r;
            chunk_in = chunk_ff + CHUNK_WIDTH'(1);
         end
         OP_TACC: begin
            term_in = divq_ff[VAL_WIDTH-1:0];
            sum_in  = k_ff[0] ? sum_ff - SUM_WIDTH'(divq_ff[VAL_WIDTH-1:0])
                              : sum_ff + SUM_WIDTH'(divq_ff[VAL_WIDTH-1:0]);
            k_in    = k_ff + K_WIDTH'(1);
         end
         OP_SERDONE: begin
            if (!phase_ff) begin
               e_in = sum_ff[VAL_WIDTH-1:0];
               // whole part present: run the series again at x = 1 for exp(-1)
               if (whole_ff != '0) begin
                  f_in     = F_ONE;
                  term_in  = Q_ONE;
                  sum_in   = SUM_WIDTH'(Q_ONE);
                  k_in     = K_WIDTH'(1);
                  phase_in = 1'b1;
               end
            end else begin
               e1_in = sum_ff[VAL_WIDTH-1:0];
            end
         end
         OP_EMUL_LO: begin
            plo_in = PLO_WIDTH'(e_ff) * PLO_WIDTH'(e1_ff[E1_LO_BITS-1:0]);
         end
         OP_EMUL_HI: begin
            e_in     = phi[E1_LO_BITS +: VAL_WIDTH];
            whole_in = whole_ff - WHOLE_BITS'(1);
         end
         OP_TAKE_CMP: begin
            take_in = {1'b0, draw_ff} < limit;
         end
         OP_TAKE_YES: begin
            take_in = 1'b1;
         end
         OP_TAKE_NO: begin
            take_in = 1'b0;
         end
         OP_EMIT: begin
            if (!emit_hold) begin
               if (take_ff) begin
                  pos_in = cand;
               end
               rsp_pos_in   = take_ff ? cand : pos_ff;
               rsp_step_in  = neg_ff ? STEP_MINUS : STEP_PLUS;
               rsp_acc_in   = take_ff;
               rsp_valid_in = 1'b1;
            end
         end
         OP_NOP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      draw_ff     <= draw_in;
      x_ff        <= x_in;
      f_ff        <= f_in;
      whole_ff    <= whole_in;
      term_ff     <= term_in;
      sum_ff      <= sum_in;
      k_ff        <= k_in;
      chunk_ff    <= chunk_in;
      divq_ff     <= divq_in;
      rem_ff      <= rem_in;
      e_ff        <= e_in;
      e1_ff       <= e1_in;
      plo_ff      <= plo_in;
      phase_ff    <= phase_in;
      take_ff     <= take_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_step_ff <= rsp_step_in;
      rsp_acc_ff  <= rsp_acc_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_position = rsp_pos_ff;
   assign rsp_step_taken   = rsp_step_ff;
   assign rsp_accepted     = rsp_acc_ff;
   assign walker_position  = pos_ff;

endmodule

@@ test/metropolis_lattice_oscillator_step_tb.sv @@
// Self-checking bench for the Metropolis lattice oscillator step: directed table, then random walks.
module metropolis_lattice_oscillator_step_tb
   import mlos_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   // Generous ceiling: the slowest items, plus long sender gaps and long
   // receiver stalls, over roughly 525 items, taken several times over.
   localparam int unsigned CYCLE_LIMIT = 3_000_000;

   localparam int DRAW_HALF = 1 << (DRAW_BITS - 1);
   localparam int POS_MIN   = -(1 << (POSITION_WIDTH - 1));
   localparam int POS_MAX   = (1 << (POSITION_WIDTH - 1)) - 1;
   localparam int PHASES    = 10;
   localparam int PHASE_ITEMS = 50;

   // One result item as the block reports it.
   typedef struct packed {
      logic signed [POSITION_WIDTH-1:0] pos;
      logic signed [STEP_WIDTH-1:0]     step;
      logic                             took;
   } outcome_type;

   // One row of the directed table. A row with load set first rewrites beta and
   // start_position once the block has drained. Rows with known set carry the
   // expected result typed in; the others are checked against the predictor.
   typedef struct packed {
      logic                        load;
      logic [BETA_WIDTH-1:0]       beta;
      logic [POSITION_WIDTH-1:0]   start;
      logic [DRAW_BITS-1:0]        dir;
      logic [DRAW_BITS-1:0]        acc;
      logic                        known;
      logic [POSITION_WIDTH-1:0]   pos;
      logic [STEP_WIDTH-1:0]       step;
      logic                        took;
   } plan_row_type;

   // load beta    start    dir      acc      known pos      step        took
   localparam plan_row_type PLAN [23] = '{
      // reset values: beta 1.0, walker at 0
      '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 16'h0000, STEP_PLUS,  1'b0},
      // direction draw exactly half steps up
      '{1'b0, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b1, 16'h0001, STEP_PLUS,  1'b1},
      // downhill move taken even with the largest accept draw
      '{1'b0, 16'h0000, 16'h0000, 16'h8001, 16'hFFFF, 1'b1, 16'h0000, STEP_MINUS, 1'b1},
      '{1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b1, 16'hFFFF, STEP_MINUS, 1'b1},
      '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 16'h0000, STEP_PLUS,  1'b1},
      // accept draw around exp(-0.5)
      '{1'b0, 16'h0000, 16'h0000, 16'h1234, 16'd39748, 1'b0, 16'h0000, STEP_PLUS, 1'b0},
      '{1'b0, 16'h0000, 16'h0000, 16'h7FFF, 16'd39749, 1'b0, 16'h0000, STEP_PLUS, 1'b0},
      // zero beta at the top of the range: leaving the range is refused
      '{1'b1, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 1'b1, 16'h7FFF, STEP_PLUS,  1'b0},
      '{1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 16'h7FFE, STEP_MINUS, 1'b1},
      // zero beta accepts any uphill move in range
      '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 16'h7FFF, STEP_PLUS,  1'b1},
      // bottom of the range
      '{1'b1, 16'h0000, 16'h8000, 16'hFFFF, 16'h0000, 1'b1, 16'h8000, STEP_MINUS, 1'b0},
      '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 16'h8001, STEP_PLUS,  1'b1},
      // largest beta: probability is zero, even draw 0 loses
      '{1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, STEP_PLUS,  1'b0},
      '{1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b1, 16'h0000, STEP_MINUS, 1'b0},
      // beta*dE of exactly 32.5: cut to zero
      '{1'b1, 16'h0100, 16'h0020, 16'h0000, 16'h0000, 1'b1, 16'h0020, STEP_PLUS,  1'b0},
      // whole part 31: longest exp(-1) chain
      '{1'b1, 16'h0100, 16'h001F, 16'h0000, 16'h0000, 1'b0, 16'h0000, STEP_PLUS,  1'b0},
      '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h5555, 1'b0, 16'h0000, STEP_PLUS,  1'b0},
      // moderate slope: small but nonzero probability
      '{1'b1, 16'h0100, 16'h0005, 16'h0000, 16'h0000, 1'b1, 16'h0006, STEP_PLUS,  1'b1},
      '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 16'h0006, STEP_PLUS,  1'b0},
      '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h00C8, 1'b0, 16'h0000, STEP_PLUS,  1'b0},
      // smallest nonzero beta, fraction-only exponent; then beta 0.5 from -16
      '{1'b1, 16'h0001, 16'hFF9C, 16'hFFFF, 16'h9C40, 1'b0, 16'h0000, STEP_PLUS,  1'b0},
      '{1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'hAAAA, 1'b0, 16'h0000, STEP_PLUS,  1'b0},
      '{1'b1, 16'h0080, 16'hFFF0, 16'hC000, 16'h0100, 1'b0, 16'h0000, STEP_PLUS,  1'b0}
   };

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [DRAW_BITS-1:0]              req_direction_draw = '0;
   logic [DRAW_BITS-1:0]              req_accept_draw = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [POSITION_WIDTH-1:0]  rsp_new_position;
   logic signed [STEP_WIDTH-1:0]      rsp_step_taken;
   logic                              rsp_accepted;
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0]         csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0]         csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0]         csr_prdata;
   logic                              csr_pready;

   // Predictor copy of the block's registers and walker.
   logic [BETA_WIDTH-1:0]             beta_setting = BETA_RESET;
   logic signed [POSITION_WIDTH-1:0]  walker_position = '0;

   outcome_type pending_moves [$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   // Sender pacing
   bit          sender_gaps = 1'b1;
   int          burst_left = 0;

   // Receiver stall pattern
   int          stall_mode = 0;
   int          stall_hold = 0;

   metropolis_lattice_oscillator_step uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_direction_draw (req_direction_draw),
      .req_accept_draw    (req_accept_draw),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_new_position   (rsp_new_position),
      .rsp_step_taken     (rsp_step_taken),
      .rsp_accepted       (rsp_accepted),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Q32 value of exp(-f/512), 20-term alternating series with truncated terms.
   function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
      logic [63:0] total;
      logic [63:0] term;
      int          k;
      total = 64'd1 << Q_BITS;
      term  = 64'd1 << Q_BITS;
      for (k = 1; k <= SERIES_TERMS; k++) begin
         term = (term * f) / (64'd512 * 64'(k));
         if (k % 2 == 1) begin
            total = total - term;
         end else begin
            total = total + term;
         end
      end
      return total;
   endfunction

   // Acceptance threshold for beta*dE = x/512: fraction part by the series, then
   // one truncated exp(-1) factor per unit of the whole part.
   function automatic logic [63:0] acceptance_bound(input logic [63:0] x);
      logic [63:0] whole;
      logic [63:0] e;
      logic [63:0] e_one;
      logic [63:0] i;
      whole = x >> FRAC_BITS;
      if (whole >= 64'd32) begin
         return 64'd0;
      end
      e     = exp_neg_frac(x & 64'd511);
      e_one = exp_neg_frac(64'd512);
      for (i = 0; i < whole; i++) begin
         e = (e * e_one) >> Q_BITS;
      end
      return e >> (Q_BITS - DRAW_BITS);
   endfunction

   // Threshold for the move the direction draw proposes from the current walker.
   // A downhill move returns 2^DRAW_BITS + 1, above every draw, so every draw passes.
   function automatic logic [63:0] proposal_bound(input logic [DRAW_BITS-1:0] dir);
      int          slope;
      logic [63:0] x;
      slope = (dir > DRAW_HALF) ? -int'(walker_position) : int'(walker_position);
      if (slope < 0) begin
         return (64'd1 << DRAW_BITS) + 64'd1;
      end
      x = 64'(beta_setting) * 64'(2 * slope + 1);
      return acceptance_bound(x);
   endfunction

   // Decide one step and advance the walker.
   function automatic outcome_type metropolis_step(input logic [DRAW_BITS-1:0] dir,
                                                   input logic [DRAW_BITS-1:0] acc);
      outcome_type o;
      int          target;
      logic        downward;
      downward = dir > DRAW_HALF;
      target   = int'(walker_position) + (downward ? -1 : 1);
      o.step   = downward ? STEP_MINUS : STEP_PLUS;
      o.took   = (target >= POS_MIN) && (target <= POS_MAX) &&
                 (64'(acc) < proposal_bound(dir));
      if (o.took) begin
         walker_position = POSITION_WIDTH'(target);
      end
      o.pos = walker_position;
      return o;
   endfunction

   // Write one register: setup cycle, then access cycle until pready.
   task automatic csr_write(input logic [REG_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'(idx) << ADDR_LSB;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // mirror the write; a start_position write also reloads the walker
      if (idx == REG_BETA) begin
         beta_setting = value[BETA_WIDTH-1:0];
      end else if (idx == REG_START) begin
         walker_position = value[POSITION_WIDTH-1:0];
      end
   endtask

   task automatic load_settings(input logic [BETA_WIDTH-1:0] beta,
                                input logic signed [POSITION_WIDTH-1:0] start);
      csr_write(REG_BETA, CSR_DATA_WIDTH'(beta));
      csr_write(REG_START, CSR_DATA_WIDTH'(start));
   endtask

   // Drop valid and hold until every expected result has come back.
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_moves.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Offer one item, hold it until accepted, queue its expected result, then
   // pace the sender: advance the burst, or start a new one after a random gap when gaps are on.
   task automatic offer_move(input logic [DRAW_BITS-1:0] dir,
                             input logic [DRAW_BITS-1:0] acc,
                             input logic use_typed,
                             input outcome_type typed);
      outcome_type predicted;
      int          gap;
      req_valid          <= 1'b1;
      req_direction_draw <= dir;
      req_accept_draw    <= acc;
      do @(posedge clock); while (req_stall);
      predicted = metropolis_step(dir, acc);
      pending_moves.push_back(use_typed ? typed : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 8);
         if (sender_gaps) begin
            // mostly short gaps, now and then one longer than a whole item
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 350)
                                              : $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Receiver: switch among free-running, coin-flip, mostly-stalled and periodic
   // stall patterns, each held for a random stretch.
   always @(posedge clock) begin
      if (stall_hold == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_hold <= $urandom_range(20, 400);
      end else begin
         stall_hold <= stall_hold - 1;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 1) == 1);
         end
         2: begin
            rsp_stall <= ($urandom_range(0, 7) != 0);
         end
         default: begin
            rsp_stall <= ((cycle_count % 16) < 5);
         end
      endcase
   end

   // Check each accepted result against the oldest expectation.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_moves.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result: pos %0d step %0d accepted %0b",
                        rsp_new_position, rsp_step_taken, rsp_accepted);
            end
         end else begin
            want = pending_moves.pop_front();
            if (rsp_new_position !== want.pos || rsp_step_taken !== want.step ||
                rsp_accepted !== want.took) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected pos %0d step %0d accepted %0b,",
                           want.pos, want.step, want.took,
                           " got pos %0d step %0d accepted %0b",
                           rsp_new_position, rsp_step_taken, rsp_accepted);
               end
            end
         end
      end
   end

   // Cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[metropolis_lattice_oscillator_step] ERROR");
         $finish;
      end
   end

   initial begin
      outcome_type                       typed;
      logic [DRAW_BITS-1:0]              dir;
      logic [DRAW_BITS-1:0]              acc;
      logic [BETA_WIDTH-1:0]             beta;
      logic signed [POSITION_WIDTH-1:0]  start;
      logic [63:0]                       bound;
      int                                phase;
      int                                n;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (PLAN[i]) begin
         if (PLAN[i].load) begin
            drain();
            load_settings(PLAN[i].beta, PLAN[i].start);
         end
         typed.pos  = PLAN[i].pos;
         typed.step = PLAN[i].step;
         typed.took = PLAN[i].took;
         offer_move(PLAN[i].dir, PLAN[i].acc, PLAN[i].known, typed);
      end

      // Random walks, each phase under fresh settings
      for (phase = 0; phase < PHASES; phase++) begin
         drain();
         case ($urandom_range(0, 7))
            0:       beta = '0;
            1:       beta = '1;
            2:       beta = BETA_WIDTH'($urandom);
            default: beta = BETA_WIDTH'($urandom_range(1, 600));
         endcase
         case ($urandom_range(0, 7))
            6:       start = POSITION_WIDTH'(POS_MAX - $urandom_range(0, 3));
            7:       start = POSITION_WIDTH'(POS_MIN + $urandom_range(0, 3));
            default: start = POSITION_WIDTH'(int'($urandom_range(0, 40)) - 20);
         endcase
         load_settings(beta, start);
         // every third phase runs the sender without gaps
         sender_gaps = (phase % 3 != 1);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            case ($urandom_range(0, 15))
               0:       dir = DRAW_BITS'(DRAW_HALF);
               1:       dir = DRAW_BITS'(DRAW_HALF + 1);
               default: dir = DRAW_BITS'($urandom);
            endcase
            // aim a quarter of the accept draws at the threshold edge when it lies in 1..2^16
            bound = proposal_bound(dir);
            acc = DRAW_BITS'($urandom);
            if ($urandom_range(0, 3) == 0 && bound != 0 &&
                bound <= (64'd1 << DRAW_BITS)) begin
               if (bound == (64'd1 << DRAW_BITS)) begin
                  acc = '1;
               end else begin
                  acc = DRAW_BITS'(bound - 64'($urandom_range(0, 1)));
               end
            end
            offer_move(dir, acc, 1'b0, typed);
         end
      end

      // Flush, then allow a margin for any stray result
      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[metropolis_lattice_oscillator_step] OK");
      end else begin
         $display("[metropolis_lattice_oscillator_step] ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/mlos_pkg.sv
hdl/mlos_sequencer.sv
hdl/mlos_datapath.sv
hdl/metropolis_lattice_oscillator_step.sv
test/metropolis_lattice_oscillator_step_tb.sv
